// ===== src/rarmt_pkg.sv =====
// Shared types, constants and helpers of the range add / range max tree.
package rarmt_pkg;

  localparam int unsigned LEAVES      = 1024;
  localparam int unsigned NODES       = 4 * LEAVES;
  localparam int unsigned NODE_AW     = $clog2(NODES);
  localparam int unsigned IDX_W       = 11;
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = STACK_AW + 1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MAX = 1'b1;

  localparam logic [IDX_W-1:0]  LEAVES_IDX = IDX_W'(LEAVES);
  localparam logic signed [63:0] MIN_VALUE = {1'b1, 63'd0};

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  range_low;
    logic [IDX_W-1:0]  range_high;
    logic signed [63:0] delta;
  } req_t;

  typedef struct packed {
    logic signed [63:0] max_value;
    logic              empty_range;
  } res_t;

  typedef struct packed {
    logic signed [63:0] pend;
    logic signed [63:0] maxv;
  } node_t;

  typedef struct packed {
    logic [NODE_AW-1:0] k;
    logic [IDX_W-1:0]   l;
    logic [IDX_W-1:0]   r;
    logic               combine;
  } frame_t;

  typedef struct packed {
    logic [IDX_W-1:0] n;
    logic             clear;
  } cfg_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_POP, S_RD_K, S_K, S_RD_LC, S_WR_LC, S_RD_RC, S_WR_RC,
    S_WR_K, S_PUSH_C, S_PUSH_R, S_PUSH_L, S_CMB_RD_L, S_CMB_RD_R, S_CMB_WR
  } state_e;

  function automatic logic signed [63:0] smax(logic signed [63:0] a,
                                              logic signed [63:0] b);
    smax = (a > b) ? a : b;
  endfunction

endpackage

// ===== src/rarmt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rarmt_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/rarmt_cfg.sv =====
// APB register holding the element count; a write also requests a tree clear.
module rarmt_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output rarmt_pkg::cfg_t       cfg_o
);
  import rarmt_pkg::*;

  logic [IDX_W-1:0] n_q, n_d;
  logic             wr;
  logic [IDX_W-1:0] v;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign v      = pwdata[IDX_W-1:0];

  always_comb begin
    n_d = n_q;
    if (wr) begin
      if (v == '0) begin
        n_d = IDX_W'(1);
      end else if (v > LEAVES_IDX) begin
        n_d = LEAVES_IDX;
      end else begin
        n_d = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= LEAVES_IDX;
    end else begin
      n_q <= n_d;
    end
  end

  assign prdata      = (paddr[2] == 1'b0) ? {{(32-IDX_W){1'b0}}, n_q} : 32'd0;
  assign cfg_o.n     = n_q;
  assign cfg_o.clear = wr;

endmodule

// ===== src/range_add_range_max_tree.sv =====
// Top level: lazy segment tree sequencer over a node memory.
// Usage: pulse start_i with a request word on req_i while busy_o is low; the
// word is taken at that edge. An add (op 0) adds delta to every element of
// [range_low, range_high] clipped to [1, elements_in_use] and gives no result.
// A max query (op 1) gives one result word on res_o, marked by res_valid_o
// for exactly one cycle; the receiver cannot stall and must take it then.
// An empty clipped range gives its result on the cycle after the start.
// Otherwise the sequencer walks the tree with a small frame stack, doing
// read-modify-write through the node memory (registered read port). A
// fully covered node is read and then updated or folded into the result; a
// split node also does a lazy push to both children (if it holds a pending
// add), frame pushes and, for adds, a recombine. busy_o stays high until
// the walk ends; one item at a time.
// After reset, and after every write of elements_in_use over the APB port,
// a clearing pass zeroes all 4096 nodes, one per cycle, with busy_o high.
module range_add_range_max_tree (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  rarmt_pkg::req_t       req_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output rarmt_pkg::res_t       res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rarmt_pkg::*;

  cfg_t cfg;

  rarmt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  logic               ram_we;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr;
  node_t              ram_wdata, ram_rdata;

  rarmt_ram #(.DEPTH(NODES), .WIDTH($bits(node_t))) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  state_e              state_q, state_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [NODE_AW-1:0]  clr_q, clr_d;
  frame_t              cur_q, cur_d;
  logic                op_q, op_d;
  logic [IDX_W-1:0]    a_q, a_d, b_q, b_d;
  logic signed [63:0]  x_q, x_d, acc_q, acc_d, t_q, t_d, kmax_q, kmax_d, lmax_q, lmax_d;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;

  frame_t              stack_q [STACK_DEPTH];
  logic                push;
  frame_t              push_frame;

  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid, lo_c, hi_c;
  logic                full, empty;
  logic [NODE_AW-1:0]  lc, rc;
  frame_t              top;

  assign mid_sum = {1'b0, cur_q.l} + {1'b0, cur_q.r};
  assign mid     = mid_sum[IDX_W:1];
  assign full    = (cur_q.l >= a_q) && (cur_q.r <= b_q);
  assign lc      = {cur_q.k[NODE_AW-2:0], 1'b0};
  assign rc      = {cur_q.k[NODE_AW-2:0], 1'b1};
  assign lo_c    = (req_i.range_low == '0) ? IDX_W'(1) : req_i.range_low;
  assign hi_c    = (req_i.range_high > cfg.n) ? cfg.n : req_i.range_high;
  assign empty   = lo_c > hi_c;
  assign top     = stack_q[STACK_AW'(sp_q - SP_W'(1))];

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    acc_d       = acc_q;
    t_d         = t_q;
    kmax_d      = kmax_q;
    lmax_d      = lmax_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    push        = 1'b0;
    push_frame  = cur_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q.k;
    ram_wdata   = '0;
    ram_raddr   = cur_q.k;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + NODE_AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          op_d  = req_i.op;
          a_d   = lo_c;
          b_d   = hi_c;
          x_d   = req_i.delta;
          acc_d = MIN_VALUE;
          if (empty) begin
            if (req_i.op == OP_MAX) begin
              res_valid_d       = 1'b1;
              res_d.max_value   = MIN_VALUE;
              res_d.empty_range = 1'b1;
            end
          end else begin
            push_frame = '{k: NODE_AW'(1), l: IDX_W'(1), r: cfg.n, combine: 1'b0};
            push       = 1'b1;
            sp_d       = SP_W'(1);
            state_d    = S_POP;
          end
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          if (op_q == OP_MAX) begin
            res_valid_d       = 1'b1;
            res_d.max_value   = acc_q;
            res_d.empty_range = 1'b0;
          end
          state_d = S_IDLE;
        end else begin
          cur_d   = top;
          sp_d    = sp_q - SP_W'(1);
          state_d = top.combine ? S_CMB_RD_L : S_RD_K;
        end
      end
      S_RD_K: begin
        ram_raddr = cur_q.k;
        state_d   = S_K;
      end
      S_K: begin
        if (full) begin
          if (op_q == OP_ADD) begin
            ram_we         = 1'b1;
            ram_wdata.pend = ram_rdata.pend + x_q;
            ram_wdata.maxv = ram_rdata.maxv + x_q;
          end else begin
            acc_d = smax(acc_q, ram_rdata.maxv);
          end
          state_d = S_POP;
        end else begin
          t_d    = ram_rdata.pend;
          kmax_d = ram_rdata.maxv;
          if (ram_rdata.pend != '0) begin
            state_d = S_RD_LC;
          end else begin
            state_d = (op_q == OP_ADD) ? S_PUSH_C : S_PUSH_R;
          end
        end
      end
      S_RD_LC: begin
        ram_raddr = lc;
        state_d   = S_WR_LC;
      end
      S_WR_LC: begin
        ram_we         = 1'b1;
        ram_waddr      = lc;
        ram_wdata.pend = ram_rdata.pend + t_q;
        ram_wdata.maxv = ram_rdata.maxv + t_q;
        state_d        = S_RD_RC;
      end
      S_RD_RC: begin
        ram_raddr = rc;
        state_d   = S_WR_RC;
      end
      S_WR_RC: begin
        ram_we         = 1'b1;
        ram_waddr      = rc;
        ram_wdata.pend = ram_rdata.pend + t_q;
        ram_wdata.maxv = ram_rdata.maxv + t_q;
        state_d        = S_WR_K;
      end
      S_WR_K: begin
        ram_we         = 1'b1;
        ram_wdata.pend = '0;
        ram_wdata.maxv = kmax_q;
        state_d        = (op_q == OP_ADD) ? S_PUSH_C : S_PUSH_R;
      end
      S_PUSH_C: begin
        push               = 1'b1;
        push_frame.combine = 1'b1;
        sp_d               = sp_q + SP_W'(1);
        state_d            = S_PUSH_R;
      end
      S_PUSH_R: begin
        if (b_q > mid) begin
          push       = 1'b1;
          push_frame = '{k: rc, l: mid + IDX_W'(1), r: cur_q.r, combine: 1'b0};
          sp_d       = sp_q + SP_W'(1);
        end
        state_d = S_PUSH_L;
      end
      S_PUSH_L: begin
        if (a_q <= mid) begin
          push       = 1'b1;
          push_frame = '{k: lc, l: cur_q.l, r: mid, combine: 1'b0};
          sp_d       = sp_q + SP_W'(1);
        end
        state_d = S_POP;
      end
      S_CMB_RD_L: begin
        ram_raddr = lc;
        state_d   = S_CMB_RD_R;
      end
      S_CMB_RD_R: begin
        lmax_d    = ram_rdata.maxv;
        ram_raddr = rc;
        state_d   = S_CMB_WR;
      end
      S_CMB_WR: begin
        // Pending add of a split node is always zero once its children exist.
        ram_we         = 1'b1;
        ram_wdata.pend = '0;
        ram_wdata.maxv = smax(lmax_q, ram_rdata.maxv);
        state_d        = S_POP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg.clear) begin
      state_d = S_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sp_q        <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    acc_q  <= acc_d;
    t_q    <= t_d;
    kmax_q <= kmax_d;
    lmax_q <= lmax_d;
    res_q  <= res_d;
    if (push) begin
      stack_q[STACK_AW'(sp_d - SP_W'(1))] <= push_frame;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q == S_IDLE))
    else $error("result word outside idle");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.empty_range) |-> (res_o.max_value == MIN_VALUE))
    else $error("empty range result is not the minimum");

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("frame stack overflow");

  a_idle_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (sp_q == '0))
    else $error("frames left on stack at idle");

endmodule

// ===== tb/sv/tb_checker.sv =====
`timescale 1ns / 1ps
// Checker for the range add / range max tree: predicts query results and compares them.
module tb_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  rarmt_pkg::req_t   req_i,
  input  logic              res_valid_o,
  input  rarmt_pkg::res_t   res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_count
);
  import rarmt_pkg::*;

  localparam int unsigned NN = 4 * LEAVES;

  logic signed [63:0] tree_max [NN];
  logic signed [63:0] tree_pend [NN];
  int unsigned        span_n;
  res_t               max_queue [$];
  int                 mismatches;

  function automatic logic signed [63:0] pick_max(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    return (a > b) ? a : b;
  endfunction

  task automatic clear_tree();
    for (int i = 0; i < NN; i++) begin
      tree_max[i] = '0;
      tree_pend[i] = '0;
    end
  endtask

  function automatic void push_pending(int unsigned k);
    logic signed [63:0] t;
    t = tree_pend[k];
    if (t != 0 && 2 * k + 1 < NN) begin
      tree_pend[2*k] += t;
      tree_pend[2*k+1] += t;
      tree_max[2*k] += t;
      tree_max[2*k+1] += t;
      tree_pend[k] = '0;
    end
  endfunction

  task automatic add_span(int unsigned k, int unsigned l, int unsigned r,
                          int unsigned a, int unsigned b, logic signed [63:0] x);
    int unsigned mid;
    if (k >= NN) return;
    if (l >= a && r <= b) begin
      tree_pend[k] += x;
      tree_max[k] += x;
      return;
    end
    push_pending(k);
    mid = (l + r) >> 1;
    if (a <= mid) add_span(2 * k, l, mid, a, b, x);
    if (b > mid) add_span(2 * k + 1, mid + 1, r, a, b, x);
    if (2 * k + 1 < NN) tree_max[k] = pick_max(tree_max[2*k], tree_max[2*k+1]);
  endtask

  function automatic logic signed [63:0] max_span(int unsigned k, int unsigned l,
                                                  int unsigned r, int unsigned a,
                                                  int unsigned b);
    int unsigned mid;
    logic signed [63:0] lv;
    logic signed [63:0] rv;
    if (k >= NN || l > b || r < a) return MIN_VALUE;
    if (l >= a && r <= b) return tree_max[k];
    push_pending(k);
    mid = (l + r) >> 1;
    lv = max_span(2 * k, l, mid, a, b);
    rv = max_span(2 * k + 1, mid + 1, r, a, b);
    return pick_max(lv, rv);
  endfunction

  task automatic apply_word(req_t w);
    int unsigned lo;
    int unsigned hi;
    res_t r;
    lo = (w.range_low < 1) ? 1 : w.range_low;
    hi = (w.range_high > span_n) ? span_n : w.range_high;
    if (w.op == OP_ADD) begin
      if (lo <= hi) add_span(1, 1, span_n, lo, hi, w.delta);
    end else begin
      if (lo > hi) begin
        r.max_value = MIN_VALUE;
        r.empty_range = 1'b1;
      end else begin
        r.max_value = max_span(1, 1, span_n, lo, hi);
        r.empty_range = 1'b0;
      end
      max_queue.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned v;
    res_t e;
    if (!rst_ni) begin
      span_n = LEAVES;
      clear_tree();
      max_queue.delete();
      mismatches = 0;
      pending_count = 0;
    end else begin
      // Results are checked before the new word so that ordering holds.
      if (res_valid_o) begin
        if (max_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word %p", res_o);
        end else begin
          e = max_queue.pop_front();
          if (res_o.max_value !== e.max_value || res_o.empty_range !== e.empty_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected max %0d empty %0b, got max %0d empty %0b",
                       e.max_value, e.empty_range, res_o.max_value, res_o.empty_range);
          end
        end
      end
      if (start_i && !busy_o) apply_word(req_i);
      if (psel && penable && pwrite && pready && paddr == 3'd0) begin
        v = pwdata[10:0];
        if (v < 1) v = 1;
        if (v > LEAVES) v = LEAVES;
        span_n = v;
        clear_tree();
      end
      pending_count = max_queue.size();
    end
  end

  assign fail_count = mismatches + 0;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the range add / range max tree: stimulus and verdict.
module tb;
  import rarmt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i = '0;
  logic        busy_o;
  logic        res_valid_o;
  res_t        res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  int unsigned cur_n = LEAVES;
  logic        late_phase = 1'b0;

  localparam int WATCHDOG = 20000;

  always #10 clk_i = ~clk_i;

  range_add_range_max_tree uut (.*);

  tb_checker u_chk (.*);

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start_i stays high from one word to the next unless an idle gap is put in before the next word.
  task automatic send_word(logic op, int unsigned lo, int unsigned hi,
                           logic signed [63:0] d);
    int gap;
    if (!late_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{op: op, range_low: lo[10:0], range_high: hi[10:0], delta: d};
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    // An add gives no result, so let the last walk finish.
    repeat (400) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_n(logic [31:0] v);
    int unsigned c;
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    c = v[10:0];
    cur_n = (c < 1) ? 1 : (c > LEAVES) ? LEAVES : c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic signed [63:0] rand_delta();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return $signed(64'($urandom_range(0, 200))) - 100;
      2: return {1'b0, {63{1'b1}}};
      3: return {1'b1, 63'd0};
      default: return $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
    endcase
  endfunction

  task automatic random_word();
    int unsigned lo;
    int unsigned hi;
    int unsigned t;
    if ($urandom_range(0, 9) == 0) begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end else begin
      lo = $urandom_range(1, cur_n);
      hi = $urandom_range(1, cur_n);
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        t = lo; lo = hi; hi = t;
      end
    end
    send_word(1'($urandom_range(0, 1)), lo, hi, rand_delta());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // Directed words: extremes, both operations, clipping and empty ranges.
    send_word(OP_MAX, 1, 1024, 0);
    send_word(OP_ADD, 1, 1024, {1'b0, {63{1'b1}}});
    send_word(OP_MAX, 1, 1024, 0);
    send_word(OP_ADD, 5, 5, 64'sd1);
    send_word(OP_MAX, 1, 1024, 0);
    send_word(OP_ADD, 0, 2047, {1'b1, 63'd0});
    send_word(OP_MAX, 0, 2047, 0);
    send_word(OP_MAX, 700, 3, 0);
    send_word(OP_ADD, 900, 10, 64'sd7);
    send_word(OP_MAX, 1024, 1024, 0);
    send_word(OP_MAX, 0, 0, 0);
    send_word(OP_ADD, 2047, 2047, -64'sd1);
    send_word(OP_MAX, 1025, 2047, 0);
    send_word(OP_ADD, 1, 1, {64{1'b1}});
    send_word(OP_MAX, 1, 2, 0);
    send_word(OP_ADD, 1024, 2047, 64'h5555_5555_AAAA_AAAA);
    send_word(OP_MAX, 1023, 1024, 0);
    send_word(OP_ADD, 1, 1024, 64'h2AAA_AAAA_5555_5555);
    send_word(OP_MAX, 1, 1024, 0);

    write_n(32'd1);
    send_word(OP_ADD, 1, 1, 64'sd3);
    send_word(OP_MAX, 1, 2047, 0);
    send_word(OP_MAX, 2, 2, 0);
    write_n(32'd0);
    send_word(OP_MAX, 1, 1, 0);
    write_n(32'hFFFF_FFFF);

    for (int i = 0; i < 1150; i++) begin
      if (i == 300) write_n(32'd2);
      if (i == 500) write_n(32'd37);
      if (i == 700) write_n(32'd1024);
      if (i == 850) write_n(32'd1500);
      if (i == 950) drain();
      if (i == 1000) late_phase = 1'b1;
      random_word();
    end
    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
